### rtl/core/modrm_ea_pkg.sv
// ----------------------------------------------------------------------------
// modrm_ea_pkg
// Shared types and field codes for the ModR/M effective address decoder.
// ----------------------------------------------------------------------------
package modrm_ea_pkg;

  localparam int unsigned WORD_W = 16;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned PIPE_DEPTH = 3;

  // mod field codes
  localparam logic [1:0] MOD_NO_DISP  = 2'd0;
  localparam logic [1:0] MOD_DISP8    = 2'd1;
  localparam logic [1:0] MOD_DISP16   = 2'd2;
  localparam logic [1:0] MOD_REGISTER = 2'd3;

  // rm field codes
  localparam logic [2:0] RM_BW_IX = 3'd0;
  localparam logic [2:0] RM_BW_IY = 3'd1;
  localparam logic [2:0] RM_BP_IX = 3'd2;
  localparam logic [2:0] RM_BP_IY = 3'd3;
  localparam logic [2:0] RM_IX    = 3'd4;
  localparam logic [2:0] RM_IY    = 3'd5;
  localparam logic [2:0] RM_BP    = 3'd6;
  localparam logic [2:0] RM_BW    = 3'd7;
  localparam logic [2:0] RM_DIRECT = RM_BP;

  // displacement byte counts
  localparam logic [1:0] DISP_NONE = 2'd0;
  localparam logic [1:0] DISP_ONE  = 2'd1;
  localparam logic [1:0] DISP_TWO  = 2'd2;

  typedef struct packed {
    logic [2:0] rm_field;
    logic [2:0] reg_field;
    logic [1:0] mod_field;
    logic       use_address;
    logic       stack_segment;
    logic [1:0] disp_bytes;
    logic       extra_wait;
  } ea_ctrl_t;

endpackage

### rtl/core/modrm_effective_address_decode_unit.sv
// ----------------------------------------------------------------------------
// modrm_effective_address_decode_unit
// Splits an 8-bit ModR/M byte and forms the effective offset, default
// segment, displacement byte count and wait penalty.
// ----------------------------------------------------------------------------
//  channel  | handshake              | payload
//  ---------+------------------------+-----------------------------------------
//  input    | start, busy            | in_modrm_byte, in_disp_word,
//           |                        | in_force_address, in_reg_*
//  result   | out_valid (one cycle)  | out_rm_field .. out_extra_wait
//
// One item per cycle; each result is registered through stage 1, stage 2 and the output register.
// Stage 1 decodes the byte and picks base, index and displacement, stage 2
// adds base and index, stage 3 adds the displacement into the output register.
// busy never rises: nothing downstream can stall, so the pipe always advances.
// Reset (rst_n low, synchronous) clears only the stage valid bits.
module modrm_effective_address_decode_unit
  import modrm_ea_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  in_modrm_byte,
  input  logic [15:0] in_disp_word,
  input  logic        in_force_address,
  input  logic [15:0] in_reg_aw,
  input  logic [15:0] in_reg_cw,
  input  logic [15:0] in_reg_dw,
  input  logic [15:0] in_reg_bw,
  input  logic [15:0] in_reg_sp,
  input  logic [15:0] in_reg_bp,
  input  logic [15:0] in_reg_ix,
  input  logic [15:0] in_reg_iy,
  output logic        out_valid,
  output logic [2:0]  out_rm_field,
  output logic [2:0]  out_reg_field,
  output logic [1:0]  out_mod_field,
  output logic        out_use_address,
  output logic [15:0] out_offset,
  output logic        out_stack_segment,
  output logic [1:0]  out_disp_bytes,
  output logic        out_extra_wait
);

  logic              accept;
  ea_ctrl_t          s1_ctrl_nxt, s1_ctrl_r, s2_ctrl_r, out_ctrl_r;
  logic [WORD_W-1:0] s1_base_nxt, s1_index_nxt, s1_disp_nxt;
  logic [WORD_W-1:0] s1_base_r, s1_index_r, s1_disp_r;
  logic [WORD_W-1:0] s2_sum_nxt, s2_sum_r, s2_disp_r;
  logic [WORD_W-1:0] out_offset_nxt, out_offset_r;
  logic              s1_valid_r, s2_valid_r, out_valid_r;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // stage 1: field split and operand selection
  always_comb begin
    logic [2:0] rm;
    logic [1:0] md;
    rm = in_modrm_byte[2:0];
    md = in_modrm_byte[7:6];

    s1_ctrl_nxt.rm_field      = rm;
    s1_ctrl_nxt.reg_field     = in_modrm_byte[5:3];
    s1_ctrl_nxt.mod_field     = md;
    s1_ctrl_nxt.use_address   = 1'b1;
    s1_ctrl_nxt.stack_segment = 1'b0;
    s1_ctrl_nxt.disp_bytes    = DISP_NONE;
    s1_ctrl_nxt.extra_wait    = 1'b0;
    s1_base_nxt  = '0;
    s1_index_nxt = '0;
    s1_disp_nxt  = '0;

    if (md == MOD_NO_DISP && rm == RM_DIRECT) begin
      // direct address, data segment
      s1_disp_nxt            = in_disp_word;
      s1_ctrl_nxt.disp_bytes = DISP_TWO;
    end else if (md == MOD_REGISTER) begin
      if (!in_force_address) begin
        s1_ctrl_nxt.use_address = 1'b0;
      end else begin
        // forced address uses its own register-pair table
        s1_ctrl_nxt.extra_wait = 1'b1;
        case (rm)
          RM_BW_IX: begin
            s1_base_nxt  = in_reg_bw;
            s1_index_nxt = in_reg_aw;
          end
          RM_BW_IY: begin
            s1_base_nxt  = in_reg_bw;
            s1_index_nxt = in_reg_cw;
          end
          RM_BP_IX: begin
            s1_base_nxt  = in_reg_bp;
            s1_index_nxt = in_reg_dw;
            s1_ctrl_nxt.stack_segment = 1'b1;
          end
          RM_BP_IY: begin
            s1_base_nxt  = in_reg_bp;
            s1_index_nxt = in_reg_bw;
            s1_ctrl_nxt.stack_segment = 1'b1;
          end
          RM_IX: begin
            s1_base_nxt  = in_reg_ix;
            s1_index_nxt = in_reg_sp;
          end
          RM_IY: begin
            s1_base_nxt  = in_reg_iy;
            s1_index_nxt = in_reg_bp;
          end
          RM_BP: begin
            s1_base_nxt  = in_reg_bp;
            s1_index_nxt = in_reg_ix;
            s1_ctrl_nxt.stack_segment = 1'b1;
          end
          default: begin
            s1_base_nxt  = in_reg_bw;
            s1_index_nxt = in_reg_iy;
          end
        endcase
      end
    end else begin
      case (rm)
        RM_BW_IX: begin
          s1_base_nxt  = in_reg_bw;
          s1_index_nxt = in_reg_ix;
          s1_ctrl_nxt.extra_wait = 1'b1;
        end
        RM_BW_IY: begin
          s1_base_nxt  = in_reg_bw;
          s1_index_nxt = in_reg_iy;
          s1_ctrl_nxt.extra_wait = 1'b1;
        end
        RM_BP_IX: begin
          s1_base_nxt  = in_reg_bp;
          s1_index_nxt = in_reg_ix;
          s1_ctrl_nxt.stack_segment = 1'b1;
          s1_ctrl_nxt.extra_wait    = 1'b1;
        end
        RM_BP_IY: begin
          s1_base_nxt  = in_reg_bp;
          s1_index_nxt = in_reg_iy;
          s1_ctrl_nxt.stack_segment = 1'b1;
          s1_ctrl_nxt.extra_wait    = 1'b1;
        end
        RM_IX:   s1_base_nxt = in_reg_ix;
        RM_IY:   s1_base_nxt = in_reg_iy;
        RM_BP: begin
          s1_base_nxt = in_reg_bp;
          s1_ctrl_nxt.stack_segment = 1'b1;
        end
        default: s1_base_nxt = in_reg_bw;
      endcase
      case (md)
        MOD_DISP8: begin
          s1_disp_nxt = {{(WORD_W-BYTE_W){in_disp_word[BYTE_W-1]}},
                         in_disp_word[BYTE_W-1:0]};
          s1_ctrl_nxt.disp_bytes = DISP_ONE;
        end
        MOD_DISP16: begin
          s1_disp_nxt = in_disp_word;
          s1_ctrl_nxt.disp_bytes = DISP_TWO;
        end
        default: s1_disp_nxt = '0;
      endcase
    end
  end

  // stage 2: base plus index, wraps at 16 bits
  assign s2_sum_nxt = s1_base_r + s1_index_r;

  // stage 3: add displacement; register mode without force reports zero
  assign out_offset_nxt = s2_ctrl_r.use_address ? (s2_sum_r + s2_disp_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= accept;
      s2_valid_r  <= s1_valid_r;
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_ctrl_r    <= s1_ctrl_nxt;
    s1_base_r    <= s1_base_nxt;
    s1_index_r   <= s1_index_nxt;
    s1_disp_r    <= s1_disp_nxt;
    s2_ctrl_r    <= s1_ctrl_r;
    s2_sum_r     <= s2_sum_nxt;
    s2_disp_r    <= s1_disp_r;
    out_ctrl_r   <= s2_ctrl_r;
    out_offset_r <= out_offset_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_rm_field      = out_ctrl_r.rm_field;
  assign out_reg_field     = out_ctrl_r.reg_field;
  assign out_mod_field     = out_ctrl_r.mod_field;
  assign out_use_address   = out_ctrl_r.use_address;
  assign out_offset        = out_offset_r;
  assign out_stack_segment = out_ctrl_r.stack_segment;
  assign out_disp_bytes    = out_ctrl_r.disp_bytes;
  assign out_extra_wait    = out_ctrl_r.extra_wait;

endmodule

### rtl/core/modrm_ea_checker.sv
// ----------------------------------------------------------------------------
// modrm_ea_checker
// Port-level checks for the ModR/M effective address decoder.
// ----------------------------------------------------------------------------
module modrm_ea_checker
  import modrm_ea_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic [7:0]  in_modrm_byte,
  input logic        out_valid,
  input logic [2:0]  out_rm_field,
  input logic [1:0]  out_mod_field,
  input logic        out_use_address,
  input logic [15:0] out_offset,
  input logic [1:0]  out_disp_bytes
);

  // every accepted item comes out after the pipe latency
  a_item_out: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##3 out_valid)
    else $error("accepted item did not produce a result");

  // no result without a matching item taken while out of reset
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(start, 3) && !$past(busy, 3) && $past(rst_n, 3)))
    else $error("result without a matching item");

  // the result fields follow the byte of the matching item
  a_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_rm_field == $past(in_modrm_byte[2:0], 3) &&
                   out_mod_field == $past(in_modrm_byte[7:6], 3)))
    else $error("result fields do not match the item byte");

  // a register operand carries no offset and consumes no displacement
  a_reg_operand: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_use_address) |-> (out_offset == '0 &&
                                         out_disp_bytes == DISP_NONE &&
                                         out_mod_field == MOD_REGISTER))
    else $error("register operand with address side effects");

endmodule

bind modrm_effective_address_decode_unit modrm_ea_checker u_modrm_ea_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .in_modrm_byte   (in_modrm_byte),
  .out_valid       (out_valid),
  .out_rm_field    (out_rm_field),
  .out_mod_field   (out_mod_field),
  .out_use_address (out_use_address),
  .out_offset      (out_offset),
  .out_disp_bytes  (out_disp_bytes)
);
